@@ hdl/fnpll_pkg.sv @@
// shared constants, codes and types of the fractional-n divider calculator
package fnpll_pkg;

   localparam int FREQ_W  = 33;
   localparam int REF_W   = 28;
   localparam int RCNT_W  = 10;
   localparam int STEP_W  = 24;
   localparam int PFD_W   = 29;
   localparam int RDEN_W  = 11;
   localparam int SDEN_W  = 30;
   localparam int INT_W   = 16;
   localparam int MOD_W   = 12;
   localparam int PROD_W  = PFD_W + MOD_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 28;

   localparam int PFD_STEPS  = PFD_W;
   localparam int MAIN_STEPS = FREQ_W;
   localparam int FRAC_STEPS = MOD_W;

   localparam logic [CSR_IDX_W-1:0] REG_REF_CLOCK  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_REF_CNT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_REF_DBL    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_REF_HALF   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CHAN_STEP  = 3'd4;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_INT   = 2'd2;
   localparam logic [1:0] STATUS_MOD   = 2'd3;

   localparam logic [FREQ_W-1:0] F_MIN_HZ   = 33'd35000000;
   localparam logic [FREQ_W-1:0] F_MAX_HZ   = 33'd4400000000;
   localparam logic [FREQ_W-1:0] F_NODIV_HZ = 33'd2200000000;
   localparam logic [FREQ_W-1:0] F_PRESC_HZ = 33'd3600000000;
   localparam logic [FREQ_W-1:0] F_BAND1_HZ = 33'd1100000000;
   localparam logic [FREQ_W-1:0] F_BAND2_HZ = 33'd550000000;
   localparam logic [FREQ_W-1:0] F_BAND3_HZ = 33'd275000000;
   localparam logic [FREQ_W-1:0] F_BAND4_HZ = 33'd137500000;
   localparam logic [FREQ_W-1:0] F_BAND5_HZ = 33'd68750000;

   localparam logic [MOD_W-1:0] MOD_MIN = 12'd2;
   localparam logic [MOD_W-1:0] MOD_MAX = 12'd4095;
   localparam logic [INT_W-1:0] INT_MAX = 16'hFFFF;

   typedef struct packed {
      logic              oor;
      logic              presc;
      logic [2:0]        code;
      logic [FREQ_W-1:0] vco;
      logic [SDEN_W-1:0] step_den;
   } meta_type;

   typedef struct packed {
      logic              oor;
      logic              presc;
      logic [2:0]        code;
      logic [PFD_W-1:0]  pfd;
      logic [FREQ_W-1:0] intq;
      logic [MOD_W-1:0]  modv;
      logic              mod_clamp;
   } carry_type;

endpackage

@@ hdl/fnpll_ifs.sv @@
// request and response channel interfaces
interface fnpll_req_if;
   logic        valid;
   logic        ready;
   logic [32:0] frequency_hz;
   modport source (output valid, output frequency_hz, input ready);
   modport sink (input valid, input frequency_hz, output ready);
endinterface

interface fnpll_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic        prescaler_sel;
   logic [2:0]  out_div_sel;
   logic [15:0] int_value;
   logic [11:0] frac_value;
   logic [11:0] frac_modulus;
   logic [28:0] pfd_hz;
   modport source (output valid, output status, output prescaler_sel, output out_div_sel,
                   output int_value, output frac_value, output frac_modulus, output pfd_hz,
                   input ready);
   modport sink (input valid, input status, input prescaler_sel, input out_div_sel,
                 input int_value, input frac_value, input frac_modulus, input pfd_hz,
                 output ready);
endinterface

@@ hdl/fnpll_pfd_div.sv @@
// pipelined restoring divider for the phase detector frequency
module fnpll_pfd_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_vld,
   input  logic [fnpll_pkg::PFD_W-1:0]  in_num,
   input  logic [fnpll_pkg::RDEN_W-1:0] in_den,
   input  fnpll_pkg::meta_type          in_meta,
   output logic                        out_vld,
   output logic [fnpll_pkg::PFD_W-1:0]  out_pfd,
   output fnpll_pkg::meta_type          out_meta
);
   import fnpll_pkg::*;

   logic              vld  [0:PFD_STEPS];
   logic [RDEN_W-1:0] rem  [0:PFD_STEPS];
   logic [PFD_W-1:0]  nq   [0:PFD_STEPS];
   logic [RDEN_W-1:0] den  [0:PFD_STEPS];
   meta_type          meta [0:PFD_STEPS];

   logic              vld_ff  [0:PFD_STEPS-1];
   logic [RDEN_W-1:0] rem_ff  [0:PFD_STEPS-1];
   logic [PFD_W-1:0]  nq_ff   [0:PFD_STEPS-1];
   logic [RDEN_W-1:0] den_ff  [0:PFD_STEPS-1];
   meta_type          meta_ff [0:PFD_STEPS-1];

   assign vld[0]  = in_vld;
   assign rem[0]  = '0;
   assign nq[0]   = in_num;
   assign den[0]  = in_den;
   assign meta[0] = in_meta;

   for (genvar k = 0; k < PFD_STEPS; k++) begin : g_step
      logic [RDEN_W:0]   trial;
      logic [RDEN_W:0]   diff;
      logic              ge;
      logic [RDEN_W-1:0] rem_in;
      logic [PFD_W-1:0]  nq_in;

      always_comb begin
         trial  = {rem[k], nq[k][PFD_W-1]};
         diff   = trial - {1'b0, den[k]};
         ge     = trial >= {1'b0, den[k]};
         rem_in = ge ? diff[RDEN_W-1:0] : trial[RDEN_W-1:0];
         nq_in  = {nq[k][PFD_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            nq_ff[k]   <= nq_in;
            den_ff[k]  <= den[k];
            meta_ff[k] <= meta[k];
         end
      end

      assign vld[k+1]  = vld_ff[k];
      assign rem[k+1]  = rem_ff[k];
      assign nq[k+1]   = nq_ff[k];
      assign den[k+1]  = den_ff[k];
      assign meta[k+1] = meta_ff[k];
   end

   assign out_vld  = vld[PFD_STEPS];
   assign out_pfd  = nq[PFD_STEPS];
   assign out_meta = meta[PFD_STEPS];

endmodule

@@ hdl/fnpll_main_div.sv @@
// pipelined dividers for int (vco / pfd) and raw mod (pfd / step)
module fnpll_main_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_vld,
   input  logic [fnpll_pkg::PFD_W-1:0]  in_pfd,
   input  fnpll_pkg::meta_type          in_meta,
   output logic                        out_vld,
   output logic [fnpll_pkg::PFD_W-1:0]  out_pfd,
   output logic [fnpll_pkg::PFD_W-1:0]  out_irem,
   output logic [fnpll_pkg::FREQ_W-1:0] out_intq,
   output logic [fnpll_pkg::FREQ_W-1:0] out_modq,
   output fnpll_pkg::meta_type          out_meta
);
   import fnpll_pkg::*;

   logic              vld  [0:MAIN_STEPS];
   logic [PFD_W-1:0]  pfd  [0:MAIN_STEPS];
   logic [PFD_W-1:0]  irem [0:MAIN_STEPS];
   logic [FREQ_W-1:0] inq  [0:MAIN_STEPS];
   logic [SDEN_W-1:0] mrem [0:MAIN_STEPS];
   logic [FREQ_W-1:0] mnq  [0:MAIN_STEPS];
   meta_type          meta [0:MAIN_STEPS];

   logic              vld_ff  [0:MAIN_STEPS-1];
   logic [PFD_W-1:0]  pfd_ff  [0:MAIN_STEPS-1];
   logic [PFD_W-1:0]  irem_ff [0:MAIN_STEPS-1];
   logic [FREQ_W-1:0] inq_ff  [0:MAIN_STEPS-1];
   logic [SDEN_W-1:0] mrem_ff [0:MAIN_STEPS-1];
   logic [FREQ_W-1:0] mnq_ff  [0:MAIN_STEPS-1];
   meta_type          meta_ff [0:MAIN_STEPS-1];

   assign vld[0]  = in_vld;
   assign pfd[0]  = in_pfd;
   assign irem[0] = '0;
   assign inq[0]  = in_meta.vco;
   assign mrem[0] = '0;
   assign mnq[0]  = {{(FREQ_W-PFD_W){1'b0}}, in_pfd};
   assign meta[0] = in_meta;

   for (genvar k = 0; k < MAIN_STEPS; k++) begin : g_step
      logic [PFD_W:0]    itrial;
      logic [PFD_W:0]    idiff;
      logic              ige;
      logic [SDEN_W:0]   mtrial;
      logic [SDEN_W:0]   mdiff;
      logic              mge;
      logic [PFD_W-1:0]  irem_in;
      logic [FREQ_W-1:0] inq_in;
      logic [SDEN_W-1:0] mrem_in;
      logic [FREQ_W-1:0] mnq_in;

      always_comb begin
         itrial  = {irem[k], inq[k][FREQ_W-1]};
         idiff   = itrial - {1'b0, pfd[k]};
         ige     = itrial >= {1'b0, pfd[k]};
         irem_in = ige ? idiff[PFD_W-1:0] : itrial[PFD_W-1:0];
         inq_in  = {inq[k][FREQ_W-2:0], ige};
         mtrial  = {mrem[k], mnq[k][FREQ_W-1]};
         mdiff   = mtrial - {1'b0, meta[k].step_den};
         mge     = mtrial >= {1'b0, meta[k].step_den};
         mrem_in = mge ? mdiff[SDEN_W-1:0] : mtrial[SDEN_W-1:0];
         mnq_in  = {mnq[k][FREQ_W-2:0], mge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            pfd_ff[k]  <= pfd[k];
            irem_ff[k] <= irem_in;
            inq_ff[k]  <= inq_in;
            mrem_ff[k] <= mrem_in;
            mnq_ff[k]  <= mnq_in;
            meta_ff[k] <= meta[k];
         end
      end

      assign vld[k+1]  = vld_ff[k];
      assign pfd[k+1]  = pfd_ff[k];
      assign irem[k+1] = irem_ff[k];
      assign inq[k+1]  = inq_ff[k];
      assign mrem[k+1] = mrem_ff[k];
      assign mnq[k+1]  = mnq_ff[k];
      assign meta[k+1] = meta_ff[k];
   end

   assign out_vld  = vld[MAIN_STEPS];
   assign out_pfd  = pfd[MAIN_STEPS];
   assign out_irem = irem[MAIN_STEPS];
   assign out_intq = inq[MAIN_STEPS];
   assign out_modq = mnq[MAIN_STEPS];
   assign out_meta = meta[MAIN_STEPS];

endmodule

@@ hdl/fnpll_frac_div.sv @@
// mod clamp, remainder times mod, and pipelined divide by pfd for frac
module fnpll_frac_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_vld,
   input  logic [fnpll_pkg::PFD_W-1:0]  in_pfd,
   input  logic [fnpll_pkg::PFD_W-1:0]  in_irem,
   input  logic [fnpll_pkg::FREQ_W-1:0] in_intq,
   input  logic [fnpll_pkg::FREQ_W-1:0] in_modq,
   input  fnpll_pkg::meta_type          in_meta,
   output logic                        out_vld,
   output logic [fnpll_pkg::MOD_W-1:0]  out_frac,
   output fnpll_pkg::carry_type         out_carry
);
   import fnpll_pkg::*;

   logic              clamp_vld_ff;
   carry_type         clamp_car_ff;
   logic [PFD_W-1:0]  clamp_irem_ff;
   logic              mult_vld_ff;
   carry_type         mult_car_ff;
   logic [PROD_W-1:0] mult_prod_ff;
   carry_type         car_in;
   logic [PROD_W-1:0] prod_in;

   always_comb begin
      car_in.oor   = in_meta.oor;
      car_in.presc = in_meta.presc;
      car_in.code  = in_meta.code;
      car_in.pfd   = in_pfd;
      car_in.intq  = in_intq;
      if (in_modq < {{(FREQ_W-MOD_W){1'b0}}, MOD_MIN}) begin
         car_in.modv      = MOD_MIN;
         car_in.mod_clamp = 1'b1;
      end else if (in_modq > {{(FREQ_W-MOD_W){1'b0}}, MOD_MAX}) begin
         car_in.modv      = MOD_MAX;
         car_in.mod_clamp = 1'b1;
      end else begin
         car_in.modv      = in_modq[MOD_W-1:0];
         car_in.mod_clamp = 1'b0;
      end
      prod_in = {{MOD_W{1'b0}}, clamp_irem_ff} * {{PFD_W{1'b0}}, clamp_car_ff.modv};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clamp_vld_ff <= 1'b0;
         mult_vld_ff  <= 1'b0;
      end else if (en) begin
         clamp_vld_ff <= in_vld;
         mult_vld_ff  <= clamp_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         clamp_car_ff  <= car_in;
         clamp_irem_ff <= in_irem;
         mult_car_ff   <= clamp_car_ff;
         mult_prod_ff  <= prod_in;
      end
   end

   logic             vld [0:FRAC_STEPS];
   logic [PFD_W-1:0] rem [0:FRAC_STEPS];
   logic [MOD_W-1:0] nq  [0:FRAC_STEPS];
   carry_type        car [0:FRAC_STEPS];

   logic             vld_ff [0:FRAC_STEPS-1];
   logic [PFD_W-1:0] rem_ff [0:FRAC_STEPS-1];
   logic [MOD_W-1:0] nq_ff  [0:FRAC_STEPS-1];
   carry_type        car_ff [0:FRAC_STEPS-1];

   assign vld[0] = mult_vld_ff;
   assign rem[0] = mult_prod_ff[PROD_W-1:MOD_W];
   assign nq[0]  = mult_prod_ff[MOD_W-1:0];
   assign car[0] = mult_car_ff;

   for (genvar k = 0; k < FRAC_STEPS; k++) begin : g_step
      logic [PFD_W:0]   trial;
      logic [PFD_W:0]   diff;
      logic             ge;
      logic [PFD_W-1:0] rem_in;
      logic [MOD_W-1:0] nq_in;

      always_comb begin
         trial  = {rem[k], nq[k][MOD_W-1]};
         diff   = trial - {1'b0, car[k].pfd};
         ge     = trial >= {1'b0, car[k].pfd};
         rem_in = ge ? diff[PFD_W-1:0] : trial[PFD_W-1:0];
         nq_in  = {nq[k][MOD_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            nq_ff[k]  <= nq_in;
            car_ff[k] <= car[k];
         end
      end

      assign vld[k+1] = vld_ff[k];
      assign rem[k+1] = rem_ff[k];
      assign nq[k+1]  = nq_ff[k];
      assign car[k+1] = car_ff[k];
   end

   assign out_vld   = vld[FRAC_STEPS];
   assign out_frac  = nq[FRAC_STEPS];
   assign out_carry = car[FRAC_STEPS];

endmodule

@@ hdl/frac_n_pll_divider_calc_core.sv @@
// fractional-n divider calculator top level: config registers, front stage, output register
// throughput: one request per cycle unless the response stalls,
// set by one quotient bit per stage in each divider
// a stalled response holds the whole pipeline; no request is lost or repeated
// reset (synchronous, active high) clears all valid bits and loads config defaults
module frac_n_pll_divider_calc_core (
   input  logic                                clock,
   input  logic                                reset,
   fnpll_req_if.sink                           req_if,
   fnpll_rsp_if.source                         rsp_if,
   input  logic                                csr_we,
   input  logic [fnpll_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [fnpll_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import fnpll_pkg::*;

   logic [REF_W-1:0]  ref_clock_ff;
   logic [RCNT_W-1:0] ref_cnt_ff;
   logic              ref_dbl_ff;
   logic              ref_half_ff;
   logic [STEP_W-1:0] chan_step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_clock_ff <= 28'd50000000;
         ref_cnt_ff   <= 10'd1;
         ref_dbl_ff   <= 1'b0;
         ref_half_ff  <= 1'b1;
         chan_step_ff <= 24'd200000;
      end else if (csr_we) begin
         case (csr_index)
            REG_REF_CLOCK: ref_clock_ff <= csr_wdata[REF_W-1:0];
            REG_REF_CNT:   ref_cnt_ff   <= csr_wdata[RCNT_W-1:0];
            REG_REF_DBL:   ref_dbl_ff   <= csr_wdata[0];
            REG_REF_HALF:  ref_half_ff  <= csr_wdata[0];
            REG_CHAN_STEP: chan_step_ff <= csr_wdata[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   logic en;
   logic rsp_vld_ff;

   assign en           = !rsp_vld_ff || rsp_if.ready;
   assign req_if.ready = en;

   // front stage: range check, band select, operand setup
   logic [FREQ_W-1:0] f;
   logic [RCNT_W-1:0] r_eff;
   meta_type          meta_in;
   logic [PFD_W-1:0]  num_in;
   logic [RDEN_W-1:0] den_in;

   always_comb begin
      f             = req_if.frequency_hz;
      meta_in.oor   = (f < F_MIN_HZ) || (f > F_MAX_HZ);
      meta_in.presc = 1'b0;
      if (f >= F_NODIV_HZ) begin
         meta_in.code  = 3'd0;
         meta_in.presc = f > F_PRESC_HZ;
      end else if (f > F_BAND1_HZ) begin
         meta_in.code = 3'd1;
      end else if (f > F_BAND2_HZ) begin
         meta_in.code = 3'd2;
      end else if (f > F_BAND3_HZ) begin
         meta_in.code = 3'd3;
      end else if (f > F_BAND4_HZ) begin
         meta_in.code = 3'd4;
      end else if (f > F_BAND5_HZ) begin
         meta_in.code = 3'd5;
      end else begin
         meta_in.code = 3'd6;
      end
      meta_in.vco      = f << meta_in.code;
      meta_in.step_den = {{(SDEN_W-STEP_W){1'b0}}, chan_step_ff} << meta_in.code;
      r_eff            = (ref_cnt_ff == '0) ? {{(RCNT_W-1){1'b0}}, 1'b1} : ref_cnt_ff;
      num_in           = ref_dbl_ff ? {ref_clock_ff, 1'b0} : {1'b0, ref_clock_ff};
      den_in           = ref_half_ff ? {r_eff, 1'b0} : {1'b0, r_eff};
   end

   logic              s0_vld_ff;
   meta_type          s0_meta_ff;
   logic [PFD_W-1:0]  s0_num_ff;
   logic [RDEN_W-1:0] s0_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else if (en) begin
         s0_vld_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_meta_ff <= meta_in;
         s0_num_ff  <= num_in;
         s0_den_ff  <= den_in;
      end
   end

   logic             pfd_vld;
   logic [PFD_W-1:0] pfd_val;
   meta_type         pfd_meta;

   fnpll_pfd_div u_pfd_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (s0_vld_ff),
      .in_num   (s0_num_ff),
      .in_den   (s0_den_ff),
      .in_meta  (s0_meta_ff),
      .out_vld  (pfd_vld),
      .out_pfd  (pfd_val),
      .out_meta (pfd_meta)
   );

   logic              main_vld;
   logic [PFD_W-1:0]  main_pfd;
   logic [PFD_W-1:0]  main_irem;
   logic [FREQ_W-1:0] main_intq;
   logic [FREQ_W-1:0] main_modq;
   meta_type          main_meta;

   fnpll_main_div u_main_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (pfd_vld),
      .in_pfd   (pfd_val),
      .in_meta  (pfd_meta),
      .out_vld  (main_vld),
      .out_pfd  (main_pfd),
      .out_irem (main_irem),
      .out_intq (main_intq),
      .out_modq (main_modq),
      .out_meta (main_meta)
   );

   logic             frac_vld;
   logic [MOD_W-1:0] frac_val;
   carry_type        frac_car;

   fnpll_frac_div u_frac_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_vld    (main_vld),
      .in_pfd    (main_pfd),
      .in_irem   (main_irem),
      .in_intq   (main_intq),
      .in_modq   (main_modq),
      .in_meta   (main_meta),
      .out_vld   (frac_vld),
      .out_frac  (frac_val),
      .out_carry (frac_car)
   );

   // result assembly
   logic [1:0]       status_in;
   logic             presc_in;
   logic [2:0]       code_in;
   logic [INT_W-1:0] int_in;
   logic [MOD_W-1:0] frac_in;
   logic [MOD_W-1:0] mod_in;
   logic [PFD_W-1:0] pfd_in;

   always_comb begin
      if (frac_car.oor) begin
         status_in = STATUS_RANGE;
         presc_in  = 1'b0;
         code_in   = 3'd0;
         int_in    = '0;
         frac_in   = '0;
         mod_in    = '0;
         pfd_in    = '0;
      end else begin
         status_in = frac_car.mod_clamp ? STATUS_MOD : STATUS_OK;
         presc_in  = frac_car.presc;
         code_in   = frac_car.code;
         int_in    = frac_car.intq[INT_W-1:0];
         frac_in   = frac_val;
         mod_in    = frac_car.modv;
         pfd_in    = frac_car.pfd;
         if (frac_car.pfd == '0) begin
            status_in = STATUS_INT;
            int_in    = INT_MAX;
            frac_in   = '0;
            mod_in    = MOD_MIN;
         end else if (frac_car.intq > {{(FREQ_W-INT_W){1'b0}}, INT_MAX}) begin
            status_in = STATUS_INT;
            int_in    = INT_MAX;
         end
      end
   end

   logic [1:0]       status_ff;
   logic             presc_ff;
   logic [2:0]       code_ff;
   logic [INT_W-1:0] int_ff;
   logic [MOD_W-1:0] frac_ff;
   logic [MOD_W-1:0] mod_ff;
   logic [PFD_W-1:0] pfd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         rsp_vld_ff <= frac_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         status_ff <= status_in;
         presc_ff  <= presc_in;
         code_ff   <= code_in;
         int_ff    <= int_in;
         frac_ff   <= frac_in;
         mod_ff    <= mod_in;
         pfd_ff    <= pfd_in;
      end
   end

   assign rsp_if.valid         = rsp_vld_ff;
   assign rsp_if.status        = status_ff;
   assign rsp_if.prescaler_sel = presc_ff;
   assign rsp_if.out_div_sel   = code_ff;
   assign rsp_if.int_value     = int_ff;
   assign rsp_if.frac_value    = frac_ff;
   assign rsp_if.frac_modulus  = mod_ff;
   assign rsp_if.pfd_hz        = pfd_ff;

`ifndef SYNTHESIS
   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && status_ff == STATUS_RANGE |-> pfd_ff == '0 && int_ff == '0 && mod_ff == '0)
      else $error("out of range response carries nonzero fields");

   a_mod_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && status_ff != STATUS_RANGE |-> mod_ff >= MOD_MIN && frac_ff < mod_ff)
      else $error("mod or frac out of bounds");

   a_zero_pfd: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && status_ff != STATUS_RANGE && pfd_ff == '0
      |-> status_ff == STATUS_INT && int_ff == INT_MAX && mod_ff == MOD_MIN)
      else $error("zero pfd not flagged");

   a_presc_band: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && presc_ff |-> code_ff == 3'd0)
      else $error("8/9 prescaler with output divider");
`endif

endmodule
